// File: rtl/core/mqll_pkg.sv
// shared types, codes and defaults of the multi-queue linked-list manager
// no dependencies; imported by every module of the block
package mqll_pkg;

   // default sizes of the queue table, the node pool and the stored data
   localparam int DEF_QUEUE_SLOTS = 64;
   localparam int DEF_NODE_POOL   = 1024;
   localparam int DEF_DATA_BITS   = 32;

   // request kinds as they arrive on the port
   localparam logic [2:0] REQ_OPEN  = 3'd0;
   localparam logic [2:0] REQ_CLOSE = 3'd1;
   localparam logic [2:0] REQ_PUSH  = 3'd2;
   localparam logic [2:0] REQ_PEEK  = 3'd3;
   localparam logic [2:0] REQ_POP   = 3'd4;

   // decoded operation handed from the front to the back
   typedef enum logic [2:0] {
      OP_OPEN,
      OP_CLOSE,
      OP_PUSH,
      OP_PEEK,
      OP_POP,
      OP_BAD
   } op_type;

   typedef enum logic [1:0] {
      STAT_OK,
      STAT_BAD_QUEUE,
      STAT_EMPTY,
      STAT_NO_SPACE
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_EXEC,
      ST_LINK2
   } back_state_type;

   typedef struct packed {
      logic [2:0]         req_type;
      logic [5:0]         queue_id;
      logic signed [31:0] push_data;
   } req_item_type;

   typedef struct packed {
      status_type         status;
      logic [5:0]         queue_out;
      logic [9:0]         node_id;
      logic signed [31:0] data_out;
      logic [9:0]         count;
   } rsp_item_type;

   // classified request waiting for the back end
   typedef struct packed {
      op_type             op;
      logic               q_ok;
      logic [5:0]         q;
      logic signed [31:0] data;
   } cmd_type;

endpackage

// File: rtl/core/mqll_front.sv
// front end: request queue of two entries that decodes and range-checks requests
// depends on mqll_pkg
module mqll_front #(
   parameter int QUEUE_SLOTS = mqll_pkg::DEF_QUEUE_SLOTS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   output logic                   full,
   input  mqll_pkg::req_item_type req_item,
   output logic                   cmd_valid,
   output mqll_pkg::cmd_type      cmd,
   input  logic                   cmd_take
);
   import mqll_pkg::*;

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   cmd_type    dec;
   logic       wr_en;
   logic       rd_en;

   // decode the request kind and check the queue number
   always_comb begin
      dec.q    = req_item.queue_id;
      dec.data = req_item.push_data;
      dec.q_ok = (req_item.queue_id != 6'd0) && (32'(req_item.queue_id) < QUEUE_SLOTS);
      case (req_item.req_type)
         REQ_OPEN:  dec.op = OP_OPEN;
         REQ_CLOSE: dec.op = OP_CLOSE;
         REQ_PUSH:  dec.op = OP_PUSH;
         REQ_PEEK:  dec.op = OP_PEEK;
         REQ_POP:   dec.op = OP_POP;
         default:   dec.op = OP_BAD;
      endcase
   end

   // queue pointers and fill level
   always_comb begin
      wr_en     = push && !full;
      rd_en     = cmd_take && cmd_valid;
      wr_ptr_in = wr_ptr_ff ^ wr_en;
      rd_ptr_in = rd_ptr_ff ^ rd_en;
      fill_in   = fill_ff + 2'(wr_en) - 2'(rd_en);
   end

   assign full      = (fill_ff == 2'd2);
   assign cmd_valid = (fill_ff != 2'd0);
   assign cmd       = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_ff[wr_ptr_ff] <= dec;
      end
   end

endmodule

// File: rtl/core/mqll_rspq.sv
// result queue of two entries between the back end and the result port
// depends on mqll_pkg
module mqll_rspq (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   wr_en,
   input  mqll_pkg::rsp_item_type wr_item,
   output logic                   wr_full,
   output logic                   empty,
   input  logic                   pop,
   output mqll_pkg::rsp_item_type rsp_item
);
   import mqll_pkg::*;

   rsp_item_type slot_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   fill_ff, fill_in;
   logic         rd_en;
   logic         wr_ok;

   // pointers and fill level
   always_comb begin
      wr_ok     = wr_en && !wr_full;
      rd_en     = pop && !empty;
      wr_ptr_in = wr_ptr_ff ^ wr_ok;
      rd_ptr_in = rd_ptr_ff ^ rd_en;
      fill_in   = fill_ff + 2'(wr_ok) - 2'(rd_en);
   end

   assign wr_full  = (fill_ff == 2'd2);
   assign empty    = (fill_ff == 2'd0);
   assign rsp_item = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_ok) begin
         slot_ff[wr_ptr_ff] <= wr_item;
      end
   end

endmodule

// File: rtl/core/mqll_back.sv
// back end: queue table, node link and value memories, free list and sequencer
// depends on mqll_pkg
module mqll_back #(
   parameter int QUEUE_SLOTS = mqll_pkg::DEF_QUEUE_SLOTS,
   parameter int NODE_POOL   = mqll_pkg::DEF_NODE_POOL,
   parameter int DATA_BITS   = mqll_pkg::DEF_DATA_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   cmd_valid,
   input  mqll_pkg::cmd_type      cmd,
   output logic                   cmd_take,
   input  logic                   rsp_full,
   output logic                   rsp_push,
   output mqll_pkg::rsp_item_type rsp
);
   import mqll_pkg::*;

   localparam int NW = $clog2(NODE_POOL);
   localparam int QW = $clog2(QUEUE_SLOTS);

   typedef struct packed {
      logic [NW-1:0] first;
      logic [NW-1:0] last;
      logic [NW-1:0] items;
   } qinfo_type;

   // memories
   qinfo_type           qinfo_mem [QUEUE_SLOTS];
   logic [NW-1:0]       link_mem  [NODE_POOL];
   logic [DATA_BITS-1:0] value_mem [NODE_POOL];

   // state
   back_state_type       state_ff, state_in;
   cmd_type              cmd_ff;
   logic [QUEUE_SLOTS-1:0] qopen_ff, qopen_in;
   logic [NW-1:0]        free_top_ff, free_top_in;
   logic [NW:0]          mark_ff, mark_in;
   logic [QW-1:0]        slot_ff, slot_in;
   logic                 slot_ok_ff, slot_ok_in;
   qinfo_type            qinfo_rd_ff;
   logic [NW-1:0]        link_rd_ff;
   logic [NW-1:0]        link_addr_ff;
   logic [NW-1:0]        free_next_ff;
   logic [DATA_BITS-1:0] value_rd_ff;
   logic [NW-1:0]        l2_addr_ff, l2_addr_in;
   logic [NW-1:0]        l2_data_ff, l2_data_in;

   // combinational controls
   logic [NW-1:0]        link_raddr;
   logic                 link_re;
   logic [NW-1:0]        link_res;
   logic [QW-1:0]        qa;
   logic                 qwr_en;
   logic [QW-1:0]        qwr_addr;
   qinfo_type            qwr_data;
   logic                 lwr_en;
   logic [NW-1:0]        lwr_addr;
   logic [NW-1:0]        lwr_data;
   logic                 vwr_en;
   qinfo_type            qi;

   // lowest closed slot above the null queue, registered
   always_comb begin
      slot_in    = '0;
      slot_ok_in = 1'b0;
      for (int i = QUEUE_SLOTS - 1; i >= 1; i--) begin
         if (!qopen_ff[i]) begin
            slot_in    = QW'(i);
            slot_ok_in = 1'b1;
         end
      end
   end

   // a link below the lowest node ever pushed still holds its reset chain
   always_comb begin
      if ((NW + 1)'(link_addr_ff) < mark_ff) begin
         link_res = (link_addr_ff == '0) ? '0 : link_addr_ff - 1'b1;
      end else begin
         link_res = link_rd_ff;
      end
   end

   assign link_re    = (state_ff == ST_IDLE) || (state_ff == ST_FETCH);
   assign link_raddr = (state_ff == ST_IDLE) ? free_top_ff : qinfo_rd_ff.first;
   assign qa         = QW'(cmd_ff.q);
   assign qi         = qinfo_rd_ff;

   // sequencer and execution of one request
   always_comb begin
      state_in    = state_ff;
      cmd_take    = 1'b0;
      rsp_push    = 1'b0;
      qopen_in    = qopen_ff;
      free_top_in = free_top_ff;
      mark_in     = mark_ff;
      l2_addr_in  = l2_addr_ff;
      l2_data_in  = l2_data_ff;
      qwr_en      = 1'b0;
      qwr_addr    = qa;
      qwr_data    = '0;
      lwr_en      = 1'b0;
      lwr_addr    = '0;
      lwr_data    = '0;
      vwr_en      = 1'b0;
      rsp.status    = STAT_OK;
      rsp.queue_out = cmd_ff.q;
      rsp.node_id   = '0;
      rsp.data_out  = '0;
      rsp.count     = '0;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid && !rsp_full) begin
               cmd_take = 1'b1;
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            rsp_push = 1'b1;
            state_in = ST_IDLE;
            if (cmd_ff.op == OP_OPEN) begin
               // open the lowest closed slot with an empty chain
               if (slot_ok_ff) begin
                  qopen_in[slot_ff] = 1'b1;
                  qwr_en            = 1'b1;
                  qwr_addr          = slot_ff;
                  rsp.queue_out     = 6'(slot_ff);
               end else begin
                  rsp.status    = STAT_NO_SPACE;
                  rsp.queue_out = '0;
               end
            end else if (cmd_ff.op == OP_BAD || !cmd_ff.q_ok || !qopen_ff[qa]) begin
               rsp.status = STAT_BAD_QUEUE;
            end else begin
               case (cmd_ff.op)
                  OP_CLOSE: begin
                     // splice the whole chain onto the free list
                     qopen_in[qa] = 1'b0;
                     if (qi.last != '0) begin
                        lwr_en      = 1'b1;
                        lwr_addr    = qi.last;
                        lwr_data    = free_top_ff;
                        free_top_in = qi.first;
                     end
                  end
                  OP_PUSH: begin
                     if (free_top_ff == '0) begin
                        rsp.status = STAT_NO_SPACE;
                        rsp.count  = 10'(qi.items);
                     end else begin
                        free_top_in    = free_next_ff;
                        vwr_en         = 1'b1;
                        lwr_en         = 1'b1;
                        lwr_addr       = free_top_ff;
                        lwr_data       = '0;
                        qwr_en         = 1'b1;
                        qwr_data.first = (qi.items == '0) ? free_top_ff : qi.first;
                        qwr_data.last  = free_top_ff;
                        qwr_data.items = qi.items + 1'b1;
                        if ((NW + 1)'(free_top_ff) < mark_ff) begin
                           mark_in = (NW + 1)'(free_top_ff);
                        end
                        rsp.node_id = 10'(free_top_ff);
                        rsp.count   = 10'(qi.items + 1'b1);
                        // old tail gets linked in a second write
                        if (qi.items != '0) begin
                           l2_addr_in = qi.last;
                           l2_data_in = free_top_ff;
                           state_in   = ST_LINK2;
                        end
                     end
                  end
                  OP_PEEK, OP_POP: begin
                     if (qi.items == '0 || qi.first == '0) begin
                        rsp.status = STAT_EMPTY;
                     end else begin
                        rsp.node_id  = 10'(qi.first);
                        rsp.data_out = $signed(32'(value_rd_ff));
                        rsp.count    = 10'(qi.items);
                        if (cmd_ff.op == OP_POP) begin
                           qwr_en         = 1'b1;
                           qwr_data.first = link_res;
                           qwr_data.items = qi.items - 1'b1;
                           qwr_data.last  = (qi.items == NW'(1)) ? '0 : qi.last;
                           lwr_en         = 1'b1;
                           lwr_addr       = qi.first;
                           lwr_data       = free_top_ff;
                           free_top_in    = qi.first;
                           rsp.count      = 10'(qi.items - 1'b1);
                        end
                     end
                  end
                  default: begin
                     rsp.status = STAT_BAD_QUEUE;
                  end
               endcase
            end
         end
         ST_LINK2: begin
            lwr_en   = 1'b1;
            lwr_addr = l2_addr_ff;
            lwr_data = l2_data_ff;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         qopen_ff    <= '0;
         free_top_ff <= NW'(NODE_POOL - 1);
         mark_ff     <= (NW + 1)'(NODE_POOL);
         slot_ok_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         qopen_ff    <= qopen_in;
         free_top_ff <= free_top_in;
         mark_ff     <= mark_in;
         slot_ok_ff  <= slot_ok_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      slot_ff    <= slot_in;
      l2_addr_ff <= l2_addr_in;
      l2_data_ff <= l2_data_in;
      if (cmd_take) begin
         cmd_ff <= cmd;
      end
      if (state_ff == ST_FETCH) begin
         free_next_ff <= link_res;
      end
   end

   // queue table memory
   always_ff @(posedge clock) begin
      if (qwr_en) begin
         qinfo_mem[qwr_addr] <= qwr_data;
      end
      if (state_ff == ST_IDLE) begin
         qinfo_rd_ff <= qinfo_mem[QW'(cmd.q)];
      end
   end

   // node link memory
   always_ff @(posedge clock) begin
      if (lwr_en) begin
         link_mem[lwr_addr] <= lwr_data;
      end
      if (link_re) begin
         link_rd_ff   <= link_mem[link_raddr];
         link_addr_ff <= link_raddr;
      end
   end

   // node value memory
   always_ff @(posedge clock) begin
      if (vwr_en) begin
         value_mem[free_top_ff] <= DATA_BITS'($unsigned(cmd_ff.data));
      end
      if (state_ff == ST_FETCH) begin
         value_rd_ff <= value_mem[qinfo_rd_ff.first];
      end
   end

endmodule

// File: rtl/core/multi_queue_linked_list_manager.sv
// top level of the multi-queue linked-list manager: front, back and result queue
// depends on mqll_pkg, mqll_front, mqll_back and mqll_rspq
//
// Many FIFO queues share one pool of nodes chained through a free list; queue 0
// and node 0 are null. A request opens, closes, pushes, peeks or pops and gives
// exactly one result. The front holds two decoded requests so new requests are
// taken while the back works; results wait in a two-entry queue. The back does
// one request at a time, through ST_IDLE, ST_FETCH and ST_EXEC, and a push onto
// a non-empty queue adds ST_LINK2, set by the read-then-write of the node link
// memory (the new node and the old tail both need a link write through its
// single write port). No clearing pass is needed after reset: link entries
// below the lowest node ever pushed read back as their reset chain.
module multi_queue_linked_list_manager #(
   parameter int QUEUE_SLOTS = mqll_pkg::DEF_QUEUE_SLOTS,
   parameter int NODE_POOL   = mqll_pkg::DEF_NODE_POOL,
   parameter int DATA_BITS   = mqll_pkg::DEF_DATA_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   output logic                   full,
   input  mqll_pkg::req_item_type req_item,
   output logic                   empty,
   input  logic                   pop,
   output mqll_pkg::rsp_item_type rsp_item
);
   import mqll_pkg::*;

   logic         cmd_valid_w;
   logic         cmd_take_w;
   cmd_type      cmd_w;
   logic         rsp_push_w;
   logic         rsp_full_w;
   rsp_item_type rsp_w;

   // request decode and queue
   mqll_front #(
      .QUEUE_SLOTS(QUEUE_SLOTS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_item  (req_item),
      .cmd_valid (cmd_valid_w),
      .cmd       (cmd_w),
      .cmd_take  (cmd_take_w)
   );

   // list engine
   mqll_back #(
      .QUEUE_SLOTS(QUEUE_SLOTS),
      .NODE_POOL  (NODE_POOL),
      .DATA_BITS  (DATA_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid_w),
      .cmd       (cmd_w),
      .cmd_take  (cmd_take_w),
      .rsp_full  (rsp_full_w),
      .rsp_push  (rsp_push_w),
      .rsp       (rsp_w)
   );

   // result queue
   mqll_rspq u_rspq (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (rsp_push_w),
      .wr_item  (rsp_w),
      .wr_full  (rsp_full_w),
      .empty    (empty),
      .pop      (pop),
      .rsp_item (rsp_item)
   );

   // a result never meets a full result queue
   assert property (@(posedge clock) disable iff (reset) rsp_push_w |-> !rsp_full_w)
      else $error("result written into a full result queue");

   // the back takes only a waiting request
   assert property (@(posedge clock) disable iff (reset) cmd_take_w |-> cmd_valid_w)
      else $error("request taken from an empty request queue");

   // an empty-queue result carries no node and no count
   assert property (@(posedge clock) disable iff (reset)
      (rsp_push_w && rsp_w.status == STAT_EMPTY) |-> (rsp_w.node_id == 10'd0 &&
         rsp_w.count == 10'd0))
      else $error("empty-queue result with node or count");

   // a take is never directly followed by a result: ST_FETCH lies between them
   assert property (@(posedge clock) disable iff (reset) cmd_take_w |=> !rsp_push_w)
      else $error("result issued one cycle after a take");

endmodule
